@@ rtl/tvoe_pkg.sv @@
// Package for the three-voice oscillator/envelope core.
// Payload structs, command codes, envelope phases and rate table.
// No dependencies.
`timescale 1ns / 1ps
package tvoe_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] PH_ATTACK  = 2'd0;
  localparam logic [1:0] PH_DECAY   = 2'd1;
  localparam logic [1:0] PH_RELEASE = 2'd2;

  localparam logic [4:0] ADDR_POT_X = 5'h19;
  localparam logic [4:0] ADDR_POT_Y = 5'h1A;
  localparam logic [4:0] ADDR_OSC3  = 5'h1B;
  localparam logic [4:0] ADDR_ENV3  = 5'h1C;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] reg_addr;
    logic [7:0] write_data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [11:0] wave_out_0;
    logic [11:0] wave_out_1;
    logic [11:0] wave_out_2;
    logic [7:0]  env_out_0;
    logic [7:0]  env_out_1;
    logic [7:0]  env_out_2;
  } out_beat_t;

  // Rate periods of the envelope counter.
  function automatic logic [15:0] rate_period(input logic [3:0] idx);
    logic [15:0] p;
    case (idx)
      4'd0: p = 16'd9;      4'd1: p = 16'd32;
      4'd2: p = 16'd63;     4'd3: p = 16'd95;
      4'd4: p = 16'd149;    4'd5: p = 16'd220;
      4'd6: p = 16'd267;    4'd7: p = 16'd313;
      4'd8: p = 16'd392;    4'd9: p = 16'd977;
      4'd10: p = 16'd1954;  4'd11: p = 16'd3907;
      4'd12: p = 16'd7813;  4'd13: p = 16'd19531;
      4'd14: p = 16'd31250; default: p = 16'd39063;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/tvoe_fifo.sv @@
// Two-entry queue between front end and voice engine.
// Uses tvoe_pkg for the beat type.
`timescale 1ns / 1ps
module tvoe_fifo
  import tvoe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_beat_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output in_beat_t pop_data_o
);
  in_beat_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

@@ rtl/tvoe_engine.sv @@
// Voice engine: registers, oscillators, envelopes, read mux, output register.
// Uses tvoe_pkg.
`timescale 1ns / 1ps
module tvoe_engine
  import tvoe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      model_i,
  input  logic      go_i,
  input  in_beat_t  beat_i,
  output logic      busy_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_o
);
  logic [15:0] freq_q [3], freq_d [3];
  logic [11:0] pw_q [3], pw_d [3];
  logic [7:0]  ctl_q [3], ctl_d [3], ad_q [3], ad_d [3], sr_q [3], sr_d [3];
  logic [23:0] acc_q [3], acc_d [3];
  logic [22:0] nse_q [3], nse_d [3];
  logic [15:0] rc_q [3], rc_d [3];
  logic [7:0]  ec_q [3], ec_d [3];
  logic [4:0]  ep_q [3], ep_d [3];
  logic [7:0]  lvl_q [3], lvl_d [3];
  logic [1:0]  ph_q [3], ph_d [3];
  logic        gp_q [3], gp_d [3];
  logic [7:0]  lw_q, lw_d;
  logic        ov_q;
  out_beat_t   out_q;

  assign busy_o      = ov_q && out_stall_i;
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  // Waveform of one voice from given state.
  function automatic logic [11:0] wave(input logic [7:0] ctl, input logic [23:0] acc,
                                       input logic [23:0] acc_src, input logic [11:0] pw,
                                       input logic [22:0] n);
    logic [11:0] r, saw, tri_w;
    logic        top;
    r   = 12'hFFF;
    saw = acc[23:12];
    if (ctl[4]) begin
      top   = acc[23] ^ (ctl[2] & acc_src[23]);
      tri_w = top ? ~acc[22:11] : acc[22:11];
      r     = r & tri_w;
    end
    if (ctl[5]) r = r & saw;
    if (ctl[6]) r = r & ((ctl[3] || saw >= pw) ? 12'hFFF : 12'h000);
    if (ctl[7]) r = r & {n[11], n[9], n[7], n[5], n[3], n[1], 6'd0};
    if (ctl[7:4] == 4'd0) r = 12'd0;
    return r;
  endfunction

  logic [23:0] adv   [3];
  logic        rose  [3];
  logic [11:0] wv    [3];
  logic [11:0] osc3_w;
  logic [7:0]  rd_d;

  always_comb begin
    logic [3:0]  idx;
    logic [15:0] rcn;
    logic [7:0]  ecn, sus;
    logic        gate;
    idx  = '0;
    rcn  = '0;
    ecn  = '0;
    sus  = '0;
    gate = 1'b0;
    for (int v = 0; v < 3; v++) begin
      freq_d[v] = freq_q[v]; pw_d[v] = pw_q[v]; ctl_d[v] = ctl_q[v];
      ad_d[v] = ad_q[v]; sr_d[v] = sr_q[v]; acc_d[v] = acc_q[v];
      nse_d[v] = nse_q[v]; rc_d[v] = rc_q[v]; ec_d[v] = ec_q[v];
      ep_d[v] = ep_q[v]; lvl_d[v] = lvl_q[v]; ph_d[v] = ph_q[v]; gp_d[v] = gp_q[v];
      adv[v]  = ctl_q[v][3] ? 24'd0 : acc_q[v] + {8'd0, freq_q[v]};
      rose[v] = !acc_q[v][23] && adv[v][23];
    end
    lw_d   = lw_q;
    rd_d   = 8'd0;
    osc3_w = wave(ctl_q[2], acc_q[2], acc_q[1], pw_q[2], nse_q[2]);

    unique case (beat_i.command)
      CMD_TICK: begin
        for (int v = 0; v < 3; v++) begin
          // Oscillator, noise and hard sync.
          if (ctl_q[v][3]) begin
            nse_d[v] = 23'h7FFFFF;
          end else if (!acc_q[v][19] && adv[v][19]) begin
            nse_d[v] = {nse_q[v][21:0], nse_q[v][22] ^ nse_q[v][17]};
          end
          acc_d[v] = (ctl_q[v][1] && rose[(v + 2) % 3]) ? 24'd0 : adv[v];
          // Envelope step.
          gate = ctl_q[v][0];
          if (gate && !gp_q[v]) ph_d[v] = PH_ATTACK;
          else if (!gate && gp_q[v]) ph_d[v] = PH_RELEASE;
          gp_d[v] = gate;
          if (ph_d[v] == PH_ATTACK) idx = ad_q[v][7:4];
          else if (ph_d[v] == PH_DECAY) idx = ad_q[v][3:0];
          else idx = sr_q[v][3:0];
          rcn = rc_q[v] + 16'd1;
          rc_d[v] = rcn;
          if (rcn == rate_period(idx)) begin
            rc_d[v] = 16'd0;
            if (ph_d[v] == PH_ATTACK) begin
              lvl_d[v] = lvl_q[v] + 8'd1;
              if (lvl_d[v] == 8'hFF) ph_d[v] = PH_DECAY;
            end else begin
              ecn = ec_q[v] + 8'd1;
              ec_d[v] = ecn;
              if (ecn == {3'd0, ep_q[v]}) begin
                ec_d[v] = 8'd0;
                sus = {sr_q[v][7:4], sr_q[v][7:4]};
                if (lvl_q[v] != 8'd0 && (ph_d[v] != PH_DECAY || lvl_q[v] != sus))
                  lvl_d[v] = lvl_q[v] - 8'd1;
                case (lvl_d[v])
                  8'hFF: ep_d[v] = 5'd1;
                  8'h5D: ep_d[v] = 5'd2;
                  8'h36: ep_d[v] = 5'd4;
                  8'h1A: ep_d[v] = 5'd8;
                  8'h0E: ep_d[v] = 5'd16;
                  8'h06: ep_d[v] = 5'd30;
                  8'h00: ep_d[v] = 5'd1;
                  default: ep_d[v] = ep_q[v];
                endcase
              end
            end
          end
        end
      end
      CMD_WRITE: begin
        lw_d = beat_i.write_data;
        for (int v = 0; v < 3; v++) begin
          if (beat_i.reg_addr == 5'(7 * v))     freq_d[v][7:0]  = beat_i.write_data;
          if (beat_i.reg_addr == 5'(7 * v + 1)) freq_d[v][15:8] = beat_i.write_data;
          if (beat_i.reg_addr == 5'(7 * v + 2)) pw_d[v][7:0]    = beat_i.write_data;
          if (beat_i.reg_addr == 5'(7 * v + 3)) pw_d[v][11:8]   = beat_i.write_data[3:0];
          if (beat_i.reg_addr == 5'(7 * v + 4)) ctl_d[v]        = beat_i.write_data;
          if (beat_i.reg_addr == 5'(7 * v + 5)) ad_d[v]         = beat_i.write_data;
          if (beat_i.reg_addr == 5'(7 * v + 6)) sr_d[v]         = beat_i.write_data;
        end
      end
      CMD_READ: begin
        case (beat_i.reg_addr) inside
          ADDR_POT_X, ADDR_POT_Y: rd_d = 8'hFF;
          ADDR_OSC3: rd_d = osc3_w[11:4];
          ADDR_ENV3: rd_d = lvl_q[2];
          default:   rd_d = model_i ? 8'd0 : lw_q;
        endcase
      end
      default: ;
    endcase

    for (int v = 0; v < 3; v++)
      wv[v] = wave(ctl_d[v], acc_d[v], acc_d[(v + 2) % 3], pw_d[v], nse_d[v]);
  end

  // State update on a taken beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < 3; v++) begin
        freq_q[v] <= '0; pw_q[v] <= '0; ctl_q[v] <= '0; ad_q[v] <= '0; sr_q[v] <= '0;
        acc_q[v] <= '0; nse_q[v] <= 23'h7FFFFF; rc_q[v] <= '0; ec_q[v] <= '0;
        ep_q[v] <= 5'd1; lvl_q[v] <= '0; ph_q[v] <= PH_RELEASE; gp_q[v] <= 1'b0;
      end
      lw_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (go_i) begin
        for (int v = 0; v < 3; v++) begin
          freq_q[v] <= freq_d[v]; pw_q[v] <= pw_d[v]; ctl_q[v] <= ctl_d[v];
          ad_q[v] <= ad_d[v]; sr_q[v] <= sr_d[v]; acc_q[v] <= acc_d[v];
          nse_q[v] <= nse_d[v]; rc_q[v] <= rc_d[v]; ec_q[v] <= ec_d[v];
          ep_q[v] <= ep_d[v]; lvl_q[v] <= lvl_d[v]; ph_q[v] <= ph_d[v]; gp_q[v] <= gp_d[v];
        end
        lw_q <= lw_d;
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      out_q.read_data  <= rd_d;
      out_q.wave_out_0 <= wv[0];
      out_q.wave_out_1 <= wv[1];
      out_q.wave_out_2 <= wv[2];
      out_q.env_out_0  <= lvl_d[0];
      out_q.env_out_1  <= lvl_d[1];
      out_q.env_out_2  <= lvl_d[2];
    end
  end
endmodule

@@ rtl/three_voice_oscillator_envelope_top.sv @@
// Top level: input queue front end, voice engine back end, model register.
// Uses tvoe_pkg, tvoe_fifo, tvoe_engine.
// A beat is written into the queue, then taken into the engine's output register,
// which drives the output. Throughput: one beat per cycle unless the output stalls;
// the two-entry queue absorbs output stalls.
// Reset: async active low; voices cleared, noise all ones, envelopes in release.
`timescale 1ns / 1ps
module three_voice_oscillator_envelope_top
  import tvoe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);
  logic     model_q;
  logic     full, empty, busy, go;
  in_beat_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) model_q <= 1'b0;
    else if (cfg_we_i) model_q <= cfg_wdata_i;
  end

  assign in_stall_o = full;
  assign go = !empty && !busy;

  tvoe_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(in_valid_i && !full), .push_data_i(in_data_i), .full_o(full),
    .pop_i(go), .empty_o(empty), .pop_data_o(head)
  );

  tvoe_engine u_engine (
    .clk_i, .rst_ni, .model_i(model_q), .go_i(go), .beat_i(head), .busy_o(busy),
    .out_valid_o, .out_stall_i, .out_o(out_data_o)
  );
endmodule

@@ rtl/tvoe_checker.sv @@
// Port-level checker for the top level, attached by bind.
// Uses tvoe_pkg.
`timescale 1ns / 1ps
module tvoe_checker
  import tvoe_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");
  a_no_out_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !$past(in_valid_i) && !$past(out_valid_o) && !$past(in_stall_o)
    && !$past(in_valid_i, 2) |-> !out_valid_o)
    else $error("output beat without input");
  a_no_valid_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("valid during reset");
endmodule

bind three_voice_oscillator_envelope_top tvoe_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

@@ tb/three_voice_oscillator_envelope_top_tb.sv @@
// Testbench for the three-voice oscillator/envelope core: a predictor mirrors voices,
// noise, envelopes and bus reads. Directed and random beats are checked at the output.
// Depends on tvoe_pkg and three_voice_oscillator_envelope_top.
`timescale 1ns / 1ps
module three_voice_oscillator_envelope_top_tb;
  import tvoe_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;  // unused code, must change nothing
  localparam int OFS_FREQ_LO = 0, OFS_FREQ_HI = 1, OFS_PW_LO = 2, OFS_PW_HI = 3;
  localparam int OFS_CTRL = 4, OFS_AD = 5, OFS_SR = 6;
  localparam logic [4:0] ADDR_FILTER_TOP = 5'h1F;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  three_voice_oscillator_envelope_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  // Voice state mirror
  logic [15:0] v_freq[3];
  logic [11:0] v_pw[3];
  logic [7:0]  v_ctl[3], v_ad[3], v_sr[3];
  logic [23:0] v_acc[3];
  logic [22:0] v_noise[3];
  logic [15:0] v_rate[3];
  logic [7:0]  v_expc[3];
  logic [4:0]  v_expp[3];
  logic [7:0]  v_lvl[3];
  logic [1:0]  v_phase[3];
  logic        v_gate[3];
  logic [7:0]  last_byte;
  logic        model_new;

  out_beat_t beats_due[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        sent = 0;
  bit        idling_on = 1'b1;
  bit        hold_req = 1'b0;

  function automatic logic [15:0] env_period(input logic [3:0] idx);
    logic [15:0] p;
    case (idx)
      4'd0: p = 16'd9;      4'd1: p = 16'd32;     4'd2: p = 16'd63;
      4'd3: p = 16'd95;     4'd4: p = 16'd149;    4'd5: p = 16'd220;
      4'd6: p = 16'd267;    4'd7: p = 16'd313;    4'd8: p = 16'd392;
      4'd9: p = 16'd977;    4'd10: p = 16'd1954;  4'd11: p = 16'd3907;
      4'd12: p = 16'd7813;  4'd13: p = 16'd19531; 4'd14: p = 16'd31250;
      default: p = 16'd39063;
    endcase
    return p;
  endfunction

  // Exponential slowdown breakpoints; 0 means keep the current period
  function automatic logic [4:0] slowdown_for(input logic [7:0] lvl);
    case (lvl) inside
      8'hFF, 8'h00: return 5'd1;
      8'h5D: return 5'd2;
      8'h36: return 5'd4;
      8'h1A: return 5'd8;
      8'h0E: return 5'd16;
      8'h06: return 5'd30;
      default: return 5'd0;
    endcase
  endfunction

  function automatic logic [11:0] wave_of(input int v);
    logic [3:0]  sel;
    logic [11:0] res, saw;
    logic        top;
    logic [22:0] n;
    sel = v_ctl[v][7:4];
    res = 12'hFFF;
    saw = v_acc[v][23:12];
    n = v_noise[v];
    if (sel == 4'd0) return 12'd0;
    if (sel[0]) begin
      top = v_acc[v][23];
      if (v_ctl[v][2]) top ^= v_acc[(v + 2) % 3][23];
      res &= top ? ~v_acc[v][22:11] : v_acc[v][22:11];
    end
    if (sel[1]) res &= saw;
    if (sel[2] && !(v_ctl[v][3] || saw >= v_pw[v])) res = 12'd0;
    if (sel[3]) res &= {n[11], n[9], n[7], n[5], n[3], n[1], 6'd0};
    return res;
  endfunction

  function automatic void step_envelope(input int v);
    logic [3:0] idx;
    logic [7:0] sus;
    logic [4:0] p;
    if (v_ctl[v][0] && !v_gate[v]) v_phase[v] = PH_ATTACK;
    else if (!v_ctl[v][0] && v_gate[v]) v_phase[v] = PH_RELEASE;
    v_gate[v] = v_ctl[v][0];
    if (v_phase[v] == PH_ATTACK) idx = v_ad[v][7:4];
    else if (v_phase[v] == PH_DECAY) idx = v_ad[v][3:0];
    else idx = v_sr[v][3:0];
    v_rate[v] = v_rate[v] + 16'd1;
    if (v_rate[v] != env_period(idx)) return;
    v_rate[v] = '0;
    if (v_phase[v] == PH_ATTACK) begin
      v_lvl[v] = v_lvl[v] + 8'd1;
      if (v_lvl[v] == 8'hFF) v_phase[v] = PH_DECAY;
      return;
    end
    v_expc[v] = v_expc[v] + 8'd1;
    if (v_expc[v] != {3'd0, v_expp[v]}) return;
    v_expc[v] = '0;
    sus = v_sr[v][7:4] * 8'h11;
    if (v_phase[v] == PH_DECAY) begin
      if (v_lvl[v] != sus && v_lvl[v] != 0) v_lvl[v]--;
    end else if (v_lvl[v] != 0) begin
      v_lvl[v]--;
    end
    p = slowdown_for(v_lvl[v]);
    if (p != 0) v_expp[v] = p;
  endfunction

  function automatic void tick_voices();
    logic        was_high[3], rose[3];
    logic [23:0] prev;
    for (int v = 0; v < 3; v++) was_high[v] = v_acc[v][23];
    for (int v = 0; v < 3; v++) begin
      prev = v_acc[v];
      if (v_ctl[v][3]) begin
        v_acc[v] = '0;
        v_noise[v] = 23'h7FFFFF;
      end else begin
        v_acc[v] = prev + {8'd0, v_freq[v]};
        if (!prev[19] && v_acc[v][19])
          v_noise[v] = {v_noise[v][21:0], v_noise[v][22] ^ v_noise[v][17]};
      end
    end
    for (int v = 0; v < 3; v++) rose[v] = !was_high[v] && v_acc[v][23];
    for (int v = 0; v < 3; v++)
      if (v_ctl[v][1] && rose[(v + 2) % 3]) v_acc[v] = '0;
    for (int v = 0; v < 3; v++) step_envelope(v);
  endfunction

  function automatic void reset_voices();
    last_byte = '0;
    model_new = 1'b0;
    for (int v = 0; v < 3; v++) begin
      v_freq[v] = '0; v_pw[v] = '0; v_ctl[v] = '0; v_ad[v] = '0; v_sr[v] = '0;
      v_acc[v] = '0; v_noise[v] = 23'h7FFFFF; v_rate[v] = '0; v_expc[v] = '0;
      v_expp[v] = 5'd1; v_lvl[v] = '0; v_phase[v] = PH_RELEASE; v_gate[v] = 1'b0;
    end
  endfunction

  // Apply one beat to the mirror and queue the result it must give
  function automatic void predict_beat(input in_beat_t b);
    out_beat_t r;
    int v;
    r = '0;
    case (b.command)
      CMD_TICK: tick_voices();
      CMD_WRITE: begin
        last_byte = b.write_data;
        if (b.reg_addr < 5'h15) begin
          v = b.reg_addr / 7;
          case (b.reg_addr % 7)
            OFS_FREQ_LO: v_freq[v][7:0] = b.write_data;
            OFS_FREQ_HI: v_freq[v][15:8] = b.write_data;
            OFS_PW_LO:   v_pw[v][7:0] = b.write_data;
            OFS_PW_HI:   v_pw[v][11:8] = b.write_data[3:0];
            OFS_CTRL:    v_ctl[v] = b.write_data;
            OFS_AD:      v_ad[v] = b.write_data;
            default:     v_sr[v] = b.write_data;
          endcase
        end
      end
      CMD_READ: begin
        case (b.reg_addr) inside
          ADDR_POT_X, ADDR_POT_Y: r.read_data = 8'hFF;
          ADDR_OSC3: r.read_data = 8'(wave_of(2) >> 4);
          ADDR_ENV3: r.read_data = v_lvl[2];
          default:   r.read_data = model_new ? 8'h00 : last_byte;
        endcase
      end
      default: ;
    endcase
    r.wave_out_0 = wave_of(0); r.wave_out_1 = wave_of(1); r.wave_out_2 = wave_of(2);
    r.env_out_0 = v_lvl[0]; r.env_out_1 = v_lvl[1]; r.env_out_2 = v_lvl[2];
    beats_due.push_back(r);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output stall: random runs, plus a long hold on request
  int stall_run = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!idling_on) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
      stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        want = beats_due.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic [4:0] addr,
                           input logic [7:0] data);
    in_beat_t b;
    b.command = cmd; b.reg_addr = addr; b.write_data = data;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    predict_beat(b);
    sent++;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_model(input logic sel);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_new = sel;
  endtask

  // Register extremes, waveforms, special addresses, unknown command
  task automatic test_directed();
    send_beat(CMD_READ, ADDR_POT_X, 8'h00);
    send_beat(CMD_READ, ADDR_POT_Y, 8'hFF);
    send_beat(CMD_WRITE, 5'(OFS_FREQ_LO), 8'hFF);
    send_beat(CMD_WRITE, 5'(OFS_FREQ_HI), 8'hFF);
    send_beat(CMD_WRITE, 5'(OFS_PW_HI), 8'hFF);
    send_beat(CMD_WRITE, 5'(OFS_CTRL), 8'hF1);   // all waveforms, gate on
    send_beat(CMD_TICK, 5'h00, 8'h00);
    send_beat(CMD_TICK, 5'h1F, 8'hFF);
    send_beat(CMD_WRITE, 5'(14 + OFS_FREQ_HI), 8'h80);
    send_beat(CMD_WRITE, 5'(14 + OFS_CTRL), 8'h17); // triangle, ring, sync, gate
    send_beat(CMD_WRITE, 5'(7 + OFS_CTRL), 8'h48);  // pulse with test bit
    send_beat(CMD_TICK, 5'h00, 8'h00);
    send_beat(CMD_READ, ADDR_OSC3, 8'h00);
    send_beat(CMD_READ, ADDR_ENV3, 8'h00);
    send_beat(CMD_WRITE, ADDR_FILTER_TOP, 8'hA5);   // filter area: last byte only
    send_beat(CMD_READ, 5'h15, 8'h00);
    send_beat(CMD_NONE, 5'h1F, 8'hFF);
    send_beat(CMD_READ, 5'(OFS_CTRL), 8'h00);
    send_beat(CMD_WRITE, 5'(OFS_CTRL), 8'h00);      // gate off, no waveform
    send_beat(CMD_TICK, 5'h00, 8'h00);
  endtask

  // Reads of write-only addresses under the newer model, then back
  task automatic test_model_select();
    set_model(1'b1);
    send_beat(CMD_WRITE, 5'h16, 8'h3C);
    send_beat(CMD_READ, 5'h16, 8'h00);
    send_beat(CMD_READ, ADDR_POT_X, 8'h00);
    send_beat(CMD_READ, ADDR_ENV3, 8'h00);
    set_model(1'b0);
    send_beat(CMD_READ, 5'h00, 8'h00);
  endtask

  // One voice programmed, gated on for a while, gated off, with noise mixed in
  task automatic play_note();
    int v;
    logic [4:0] base;
    v = $urandom_range(0, 2);
    base = 5'(7 * v);
    send_beat(CMD_WRITE, base + 5'(OFS_FREQ_LO), 8'($urandom));
    send_beat(CMD_WRITE, base + 5'(OFS_FREQ_HI),
              ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8, 255)));
    send_beat(CMD_WRITE, base + 5'(OFS_PW_LO), 8'($urandom));
    send_beat(CMD_WRITE, base + 5'(OFS_PW_HI), 8'($urandom));
    send_beat(CMD_WRITE, base + 5'(OFS_AD),
              {4'($urandom_range(0, 1)), 4'($urandom_range(0, 2))});
    send_beat(CMD_WRITE, base + 5'(OFS_SR), {4'($urandom), 4'($urandom_range(0, 1))});
    send_beat(CMD_WRITE, base + 5'(OFS_CTRL), {4'($urandom), 3'($urandom), 1'b1});
    repeat ($urandom_range(20, 90)) begin
      case ($urandom_range(0, 19))
        0: send_beat(2'($urandom), 5'($urandom), 8'($urandom));
        1: send_beat(CMD_READ, ($urandom_range(0, 1) == 0) ? ADDR_OSC3 : ADDR_ENV3, 8'h00);
        default: send_beat(CMD_TICK, 5'($urandom), 8'($urandom));
      endcase
    end
    send_beat(CMD_WRITE, base + 5'(OFS_CTRL), {4'($urandom), 3'($urandom), 1'b0});
    repeat ($urandom_range(5, 30)) send_beat(CMD_TICK, 5'h00, 8'h00);
  endtask

  task automatic test_random_notes(input int beats_wanted);
    int start;
    start = sent;
    while (sent - start < beats_wanted) begin
      if ($urandom_range(0, 7) == 0) begin
        idling_on = ~idling_on;  // stretches without idling
      end
      play_note();
    end
    idling_on = 1'b1;
  endtask

  // Output held off long while beats keep coming, so the input stalls
  task automatic test_backpressure();
    wait_drained();
    hold_req = 1'b1;
    repeat (20) send_beat(CMD_TICK, 5'h00, 8'h00);
    wait_drained();
  endtask

  initial begin
    reset_voices();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_model_select();
    test_random_notes(650);
    test_backpressure();
    set_model(1'b1);
    test_random_notes(620);
    set_model(1'b0);
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
